@@ rtl/ppct_pkg.sv @@
// ----------------------------------------------------------------------------
// ppct_pkg
// Shared types and constants of the pointer packet cursor tracker.
// ----------------------------------------------------------------------------
package ppct_pkg;

  // coordinate and register widths
  localparam int unsigned PosW   = 12;
  localparam int unsigned BtnW   = 3;
  localparam int unsigned CfgIdxW = 1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_X_LIMIT = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_Y_LIMIT = 1'd1;

  // reset values
  localparam logic [PosW-1:0] X_LIMIT_RST = 12'd1023;
  localparam logic [PosW-1:0] Y_LIMIT_RST = 12'd767;
  localparam logic [PosW-1:0] POS_X_RST   = 12'd640;
  localparam logic [PosW-1:0] POS_Y_RST   = 12'd512;

  // header bit positions
  localparam int unsigned HdrXSignBit = 4;
  localparam int unsigned HdrYSignBit = 5;

  // one completed movement packet
  typedef struct packed {
    logic [7:0] header;
    logic [7:0] x_move;
    logic [7:0] y_move;
  } pkt_t;

  // cursor position pair
  typedef struct packed {
    logic [PosW-1:0] x;
    logic [PosW-1:0] y;
  } pos_t;

endpackage

@@ rtl/ppct_rx_if.sv @@
// ----------------------------------------------------------------------------
// ppct_rx_if
// Valid/ready channel carrying one received packet byte per beat.
// ----------------------------------------------------------------------------
interface ppct_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/ppct_res_if.sv @@
// ----------------------------------------------------------------------------
// ppct_res_if
// Valid/ready channel carrying one cursor result per beat.
// ----------------------------------------------------------------------------
interface ppct_res_if;
  logic        valid;
  logic        ready;
  logic [11:0] cursor_x;
  logic [11:0] cursor_y;
  logic [2:0]  buttons_now;
  logic [2:0]  pressed_edges;
  logic [2:0]  released_edges;

  modport source (output valid, output cursor_x, output cursor_y, output buttons_now,
                  output pressed_edges, output released_edges, input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, input buttons_now,
                  input pressed_edges, input released_edges, output ready);
endinterface

@@ rtl/ppct_cursor_calc.sv @@
// ----------------------------------------------------------------------------
// ppct_cursor_calc
// Applies one packet's signed moves to the cursor and clamps each axis.
// ----------------------------------------------------------------------------
module ppct_cursor_calc import ppct_pkg::*; (
  input  pkt_t            pkt_i,
  input  pos_t            pos_i,
  input  logic [PosW-1:0] x_limit_i,
  input  logic [PosW-1:0] y_limit_i,
  output pos_t            pos_o
);

  logic              x_sign;
  logic              y_sign;
  logic signed [13:0] x_sum;
  logic signed [13:0] y_sum;
  logic [13:0]        x_low;
  logic [13:0]        y_low;

  // 9-bit signed moves, header bits give the sign
  assign x_sign = pkt_i.header[HdrXSignBit];
  assign y_sign = pkt_i.header[HdrYSignBit];

  // x grows with the move, y grows downward
  assign x_sum = $signed({2'b00, pos_i.x}) + $signed({{5{x_sign}}, x_sign, pkt_i.x_move});
  assign y_sum = $signed({2'b00, pos_i.y}) - $signed({{5{y_sign}}, y_sign, pkt_i.y_move});

  // lower clamp to one first
  assign x_low = (x_sum < 14'sd1) ? 14'd1 : 14'(x_sum);
  assign y_low = (y_sum < 14'sd1) ? 14'd1 : 14'(y_sum);

  // upper clamp to the limit last, so a zero limit gives zero
  assign pos_o.x = (x_low > {2'b00, x_limit_i}) ? x_limit_i : x_low[PosW-1:0];
  assign pos_o.y = (y_low > {2'b00, y_limit_i}) ? y_limit_i : y_low[PosW-1:0];

endmodule

@@ rtl/pointer_packet_cursor_tracker_core.sv @@
// ----------------------------------------------------------------------------
// pointer_packet_cursor_tracker_core
// Decodes three-byte pointer packets into a clamped cursor and button edges.
// ----------------------------------------------------------------------------
// Usage:
//   rx_i carries one packet byte per beat: header, x move, y move, repeating.
//   Each third byte yields one beat on res_o with the clamped cursor, the
//   button state and the press/release edges against the previous packet.
//   The first two bytes of a packet yield no result.
//   Bytes go into an input register and are decoded from there; a
//   result beat enters the result register once that register is free.
//   One byte per cycle is taken unless res_o stalls; the decode step is a
//   single add and clamp per axis between the input and result registers.
//   When res_o stalls, the finished result holds in the result register and
//   one more byte waits in the input register; header and x-move bytes keep
//   flowing until a third byte meets a full result register.
//   Reset returns to the header byte, cursor (640, 512), no buttons held,
//   limits 1023 and 767. cfg_we_i writes a limit by index.
// ----------------------------------------------------------------------------
module pointer_packet_cursor_tracker_core import ppct_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  ppct_rx_if.sink            rx_i,
  ppct_res_if.source         res_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [PosW-1:0]    cfg_wdata_i
);

  // packet byte phase
  localparam logic [1:0] PH_HEAD  = 2'd0;
  localparam logic [1:0] PH_XMOVE = 2'd1;
  localparam logic [1:0] PH_YMOVE = 2'd2;

  logic [PosW-1:0] x_limit_q;
  logic [PosW-1:0] y_limit_q;
  logic [1:0]      phase_q, phase_d;
  logic [7:0]      header_q;
  logic [7:0]      x_move_q;
  pos_t            pos_q;
  logic [BtnW-1:0] last_btn_q;
  logic            s1_vld_q;
  logic [7:0]      s1_byte_q;
  logic            res_vld_q, res_vld_d;
  pos_t            res_pos_q;
  logic [BtnW-1:0] res_btn_q;
  logic [BtnW-1:0] res_press_q;
  logic [BtnW-1:0] res_rel_q;

  logic            is_last;
  logic            out_free;
  logic            s1_fire;
  logic            res_load;
  pkt_t            pkt;
  pos_t            pos_new;
  logic [BtnW-1:0] btn_now;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_limit_q <= X_LIMIT_RST;
      y_limit_q <= Y_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_X_LIMIT: x_limit_q <= cfg_wdata_i;
        REG_Y_LIMIT: y_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // handshake between input register and result register
  assign is_last  = (phase_q == PH_YMOVE);
  assign out_free = !res_vld_q || res_o.ready;
  assign s1_fire  = s1_vld_q && (!is_last || out_free);
  assign res_load = s1_fire && is_last;
  assign rx_i.ready = !s1_vld_q || s1_fire;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (rx_i.ready) begin
      s1_vld_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      s1_byte_q <= rx_i.rx_byte;
    end
  end

  // phase sequencing, an unused code takes its byte as a header and moves on to the x move
  always_comb begin
    unique case (phase_q)
      PH_HEAD:  phase_d = PH_XMOVE;
      PH_XMOVE: phase_d = PH_YMOVE;
      PH_YMOVE: phase_d = PH_HEAD;
      default:  phase_d = PH_XMOVE;
    endcase
  end

  // decode of the completed packet
  assign pkt.header = header_q;
  assign pkt.x_move = x_move_q;
  assign pkt.y_move = s1_byte_q;
  assign btn_now    = header_q[BtnW-1:0];

  ppct_cursor_calc u_calc (
    .pkt_i     (pkt),
    .pos_i     (pos_q),
    .x_limit_i (x_limit_q),
    .y_limit_i (y_limit_q),
    .pos_o     (pos_new)
  );

  // packet state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEAD;
      header_q   <= '0;
      x_move_q   <= '0;
      pos_q.x    <= POS_X_RST;
      pos_q.y    <= POS_Y_RST;
      last_btn_q <= '0;
    end else if (s1_fire) begin
      phase_q <= phase_d;
      priority if (phase_q == PH_XMOVE) begin
        x_move_q <= s1_byte_q;
      end else if (is_last) begin
        pos_q      <= pos_new;
        last_btn_q <= btn_now;
      end else begin
        header_q <= s1_byte_q;
      end
    end
  end

  // result register
  always_comb begin
    res_vld_d = res_vld_q;
    if (res_load) begin
      res_vld_d = 1'b1;
    end else if (res_o.ready) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_pos_q   <= pos_new;
      res_btn_q   <= btn_now;
      res_press_q <= btn_now & ~last_btn_q;
      res_rel_q   <= last_btn_q & ~btn_now;
    end
  end

  assign res_o.valid          = res_vld_q;
  assign res_o.cursor_x       = res_pos_q.x;
  assign res_o.cursor_y       = res_pos_q.y;
  assign res_o.buttons_now    = res_btn_q;
  assign res_o.pressed_edges  = res_press_q;
  assign res_o.released_edges = res_rel_q;

endmodule

@@ rtl/ppct_checker.sv @@
// ----------------------------------------------------------------------------
// ppct_checker
// Port-level checks of the cursor tracker, bound to the top level.
// ----------------------------------------------------------------------------
module ppct_checker import ppct_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [BtnW-1:0] out_btn,
  input logic [BtnW-1:0] out_press,
  input logic [BtnW-1:0] out_rel
);

  logic [1:0]      beat_cnt_q;
  logic [2:0]      pending_q;
  logic [BtnW-1:0] last_btn_q;
  logic            in_acc;
  logic            out_acc;
  logic            pkt_done;

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign pkt_done = in_acc && (beat_cnt_q == 2'd2);

  // track packet position, open results and last delivered buttons
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_cnt_q <= 2'd0;
      pending_q  <= 3'd0;
      last_btn_q <= '0;
    end else begin
      if (in_acc) begin
        beat_cnt_q <= (beat_cnt_q == 2'd2) ? 2'd0 : beat_cnt_q + 2'd1;
      end
      pending_q <= pending_q + {2'b00, pkt_done} - {2'b00, out_acc};
      if (out_acc) begin
        last_btn_q <= out_btn;
      end
    end
  end

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // no result without a completed packet
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> pending_q != 3'd0)
    else $error("result beat without a completed packet");

  // at most one result held and one in decode
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd2)
    else $error("too many completed packets outstanding");

  // press edges against the previous delivered packet
  a_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> out_press == (out_btn & ~last_btn_q))
    else $error("press edges disagree with previous buttons");

  // release edges against the previous delivered packet
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> out_rel == (last_btn_q & ~out_btn))
    else $error("release edges disagree with previous buttons");

endmodule

bind pointer_packet_cursor_tracker_core ppct_checker u_ppct_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (rx_i.valid),
  .in_ready  (rx_i.ready),
  .out_valid (res_o.valid),
  .out_ready (res_o.ready),
  .out_btn   (res_o.buttons_now),
  .out_press (res_o.pressed_edges),
  .out_rel   (res_o.released_edges)
);

@@ tb/sv/pointer_packet_cursor_tracker_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pointer_packet_cursor_tracker_core_tb
// Streams packet bytes into the cursor tracker and tracks the cursor, the
// buttons and the press/release edges alongside it. Every result beat is
// compared field by field in arrival order. The run covers directed packets,
// limit extremes, back-pressure and random traffic under random limits.
// ----------------------------------------------------------------------------
module pointer_packet_cursor_tracker_core_tb;
  import ppct_pkg::*;

  localparam int unsigned HalfPeriod  = 4;
  localparam int unsigned ResetCycles = 12;
  localparam int unsigned MaxGap      = 18;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned StallLimit  = 3000;
  localparam int          SignWeight  = 256;
  localparam logic [PosW-1:0] PosMax  = 12'd4095;

  // byte position inside a packet
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_X_MOVE,
    PH_Y_MOVE
  } byte_phase_e;

  // one expected result beat
  typedef struct packed {
    logic [PosW-1:0] cursor_x;
    logic [PosW-1:0] cursor_y;
    logic [BtnW-1:0] buttons_now;
    logic [BtnW-1:0] pressed_edges;
    logic [BtnW-1:0] released_edges;
  } cursor_beat_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [PosW-1:0]   cfg_wdata_i;

  ppct_rx_if  rx_if ();
  ppct_res_if res_if ();

  pointer_packet_cursor_tracker_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // tracker state mirrored in the testbench
  byte_phase_e     trk_phase;
  logic [7:0]      trk_header;
  logic [7:0]      trk_x_move;
  logic [PosW-1:0] trk_pos_x;
  logic [PosW-1:0] trk_pos_y;
  logic [BtnW-1:0] trk_last_btn;
  logic [PosW-1:0] trk_x_limit;
  logic [PosW-1:0] trk_y_limit;

  cursor_beat_t cursor_expect_q[$];
  int unsigned  mismatch_cnt;
  int unsigned  idle_cnt;
  int unsigned  res_hold_req;
  bit           tx_burst;
  bit           rx_burst;

  // clock
  initial clk_i = 1'b0;
  always #(HalfPeriod) clk_i = ~clk_i;

  // clamp to one first, then to the limit
  function automatic logic [PosW-1:0] clamp_coord(input int v, input logic [PosW-1:0] lim);
    if (v < 1) v = 1;
    if (v > int'(lim)) v = int'(lim);
    return v[PosW-1:0];
  endfunction

  // advance the mirrored tracker by one accepted byte
  task automatic track_byte(input logic [7:0] b);
    int           dx;
    int           dy;
    cursor_beat_t beat;
    case (trk_phase)
      PH_X_MOVE: begin
        trk_x_move = b;
        trk_phase  = PH_Y_MOVE;
      end
      PH_Y_MOVE: begin
        trk_phase = PH_HEADER;
        dx = int'(trk_x_move) - (trk_header[HdrXSignBit] ? SignWeight : 0);
        dy = int'(b) - (trk_header[HdrYSignBit] ? SignWeight : 0);
        trk_pos_x = clamp_coord(int'(trk_pos_x) + dx, trk_x_limit);
        trk_pos_y = clamp_coord(int'(trk_pos_y) - dy, trk_y_limit);
        beat.cursor_x       = trk_pos_x;
        beat.cursor_y       = trk_pos_y;
        beat.buttons_now    = trk_header[BtnW-1:0];
        beat.pressed_edges  = trk_header[BtnW-1:0] & ~trk_last_btn;
        beat.released_edges = trk_last_btn & ~trk_header[BtnW-1:0];
        trk_last_btn        = trk_header[BtnW-1:0];
        cursor_expect_q.push_back(beat);
      end
      default: begin
        trk_header = b;
        trk_phase  = PH_X_MOVE;
      end
    endcase
  endtask

  // offer one byte after a random gap, none in a burst, and wait for it to be taken
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    track_byte(b);
  endtask

  task automatic send_packet(input logic [7:0] hdr, input logic [7:0] xm,
                             input logic [7:0] ym);
    send_byte(hdr);
    send_byte(xm);
    send_byte(ym);
  endtask

  // stop offering and wait until every result beat is in
  task automatic wait_drained();
    rx_if.valid <= 1'b0;
    while (cursor_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // write both limits on back-to-back cycles, block idle
  task automatic set_limits(input logic [PosW-1:0] x_lim, input logic [PosW-1:0] y_lim);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_X_LIMIT;
    cfg_wdata_i <= x_lim;
    @(posedge clk_i);
    cfg_idx_i   <= REG_Y_LIMIT;
    cfg_wdata_i <= y_lim;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    trk_x_limit = x_lim;
    trk_y_limit = y_lim;
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [PosW-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return PosMax;
      1:       return 12'd1;
      2:       return 12'($urandom_range(1, 64));
      default: return 12'($urandom_range(1, 4095));
    endcase
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  // compare a taken result beat with the oldest expectation
  task automatic check_cursor_beat();
    cursor_beat_t exp_b;
    if (cursor_expect_q.size() == 0) begin
      $error("result beat with no expectation: x %0d y %0d", res_if.cursor_x,
             res_if.cursor_y);
      mismatch_cnt++;
    end else begin
      exp_b = cursor_expect_q.pop_front();
      check_field("cursor_x", exp_b.cursor_x, res_if.cursor_x);
      check_field("cursor_y", exp_b.cursor_y, res_if.cursor_y);
      check_field("buttons_now", exp_b.buttons_now, res_if.buttons_now);
      check_field("pressed_edges", exp_b.pressed_edges, res_if.pressed_edges);
      check_field("released_edges", exp_b.released_edges, res_if.released_edges);
    end
  endtask

  // result sink with random stalls and requested long hold-offs
  initial begin
    int unsigned stall;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (res_hold_req > 0) begin
        stall        = res_hold_req;
        res_hold_req = 0;
      end else begin
        stall = rx_burst ? 0 : $urandom_range(0, MaxGap);
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      check_cursor_beat();
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cnt <= 0;
      end else if (idle_cnt >= StallLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
    end
  end

  // zero move from reset, all header bits, sign extremes and button edges
  task automatic test_directed_packets();
    send_packet(8'h08, 8'h00, 8'h00);
    send_packet(8'h0F, 8'hFF, 8'hFF);
    send_packet(8'h38, 8'h00, 8'h00);
    send_packet(8'hFD, 8'h01, 8'h80);
    send_packet(8'h12, 8'h80, 8'h7F);
    send_packet(8'h25, 8'h7F, 8'hFF);
    send_packet(8'hC6, 8'hAA, 8'h55);
    send_packet(8'h1B, 8'h01, 8'h00);
    wait_drained();
  endtask

  // zero and one limits, full range walks, limit change mid-packet
  task automatic test_limit_extremes();
    set_limits(12'd0, 12'd0);
    send_packet(8'h00, 8'h10, 8'h10);
    wait_drained();
    set_limits(12'd1, 12'd1);
    send_packet(8'h01, 8'hFF, 8'h00);
    wait_drained();
    set_limits(PosMax, PosMax);
    // push right and down until both clamp at the top
    repeat (18) send_packet(8'h20, 8'hFF, 8'h00);
    wait_drained();
    // stored position is only clamped on the next packet
    send_byte(8'h02);
    wait_drained();
    set_limits(12'd100, 12'd50);
    send_byte(8'h00);
    send_byte(8'h00);
    send_packet(8'h04, 8'h00, 8'h00);
    // pull left and up until both clamp at one
    repeat (3) send_packet(8'h10, 8'h00, 8'hFF);
    wait_drained();
    set_limits(X_LIMIT_RST, Y_LIMIT_RST);
  endtask

  // long sink hold-off while bytes keep coming, then a full drain
  task automatic test_backpressure();
    tx_burst     = 1'b1;
    res_hold_req = HoldCycles;
    repeat (15) send_packet(rand_byte(), rand_byte(), rand_byte());
    tx_burst = 1'b0;
    wait_drained();
  endtask

  // random packets under random limits and idle patterns
  task automatic test_random_traffic();
    int unsigned n_bytes;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) set_limits(pick_limit(), pick_limit());
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      // counts that are not a multiple of three leave a packet open across the limit write
      n_bytes = 128 + $urandom_range(0, 4);
      repeat (n_bytes) send_byte(rand_byte());
      wait_drained();
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  // reset, then the tests in turn
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_X_LIMIT;
    cfg_wdata_i   = '0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    mismatch_cnt  = 0;
    idle_cnt      = 0;
    res_hold_req  = 0;
    tx_burst      = 1'b0;
    rx_burst      = 1'b0;
    trk_phase     = PH_HEADER;
    trk_header    = '0;
    trk_x_move    = '0;
    trk_pos_x     = POS_X_RST;
    trk_pos_y     = POS_Y_RST;
    trk_last_btn  = '0;
    trk_x_limit   = X_LIMIT_RST;
    trk_y_limit   = Y_LIMIT_RST;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_packets();
    test_limit_extremes();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ pointer_packet_cursor_tracker_core.f @@
rtl/ppct_pkg.sv
rtl/ppct_rx_if.sv
rtl/ppct_res_if.sv
rtl/ppct_cursor_calc.sv
rtl/pointer_packet_cursor_tracker_core.sv
rtl/ppct_checker.sv
tb/sv/pointer_packet_cursor_tracker_core_tb.sv
